// File: design/psp_pkg.sv
// shared types and constants for the printf conversion spec parser
`default_nettype none

package psp_pkg;

    // parse phase, one-hot
    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_FLAGS = 8'b0000_0010,
        PH_WIDTH = 8'b0000_0100,
        PH_DOT   = 8'b0000_1000,
        PH_PREC  = 8'b0001_0000,
        PH_LEN_H = 8'b0010_0000,
        PH_LEN_L = 8'b0100_0000,
        PH_SPEC  = 8'b1000_0000
    } phase_t;

    // length codes, also the low arg_type codes
    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_INT  = 2'd1;
    localparam logic [1:0] LEN_LONG = 2'd2;
    localparam logic [1:0] LEN_LL   = 2'd3;

    localparam logic [2:0] ARG_ULONG = 3'd4;
    localparam logic [2:0] ARG_ULL   = 3'd5;

    // flag bit positions
    localparam int FLAG_MINUS = 0;
    localparam int FLAG_PLUS  = 1;
    localparam int FLAG_SPACE = 2;
    localparam int FLAG_HASH  = 3;
    localparam int FLAG_ZERO  = 4;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_US    = 8'h53;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_PCT   = 8'h25;

    typedef struct packed {
        logic [7:0] char_in;
        logic       start_req;
    } psp_in_t;

    typedef struct packed {
        logic [4:0]  flags_mask;
        logic        has_width;
        logic [15:0] width_value;
        logic        has_precision;
        logic [15:0] precision_value;
        logic [2:0]  arg_type;
        logic [7:0]  spec_char;
        logic [7:0]  span_length;
        logic        ended_before_current;
        logic        number_saturated;
    } psp_out_t;

endpackage

`default_nettype wire

// File: design/psp_in_if.sv
// valid/ready channel carrying format string bytes
`default_nettype none

interface psp_in_if
    import psp_pkg::*;
;
    logic    valid;
    logic    ready;
    psp_in_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: design/psp_out_if.sv
// valid/ready channel carrying parsed conversion specs
`default_nettype none

interface psp_out_if
    import psp_pkg::*;
;
    logic     valid;
    logic     ready;
    psp_out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: design/printf_spec_parser.sv
// printf conversion spec parser: byte-per-cycle parse with skid-buffered result
//
//  channel | dir | payload                         | transaction
//  --------+-----+---------------------------------+------------------------------
//  text    | in  | char_in, start_req              | one format byte
//  spec    | out | flags, width, precision, type.. | one finished conversion spec
//
// one byte is taken per cycle while text is ready; the parse state updates in
// the accepting cycle and a finished spec goes to the result register or skid
// rst_n clears the parse to idle and empties the result registers
// a result register plus a one-entry skid keeps text ready while spec stalls;
// text drops ready only when both hold results
`default_nettype none

module printf_spec_parser
    import psp_pkg::*;
#(
    parameter int NUMBER_BITS = 16
) (
    input  wire        clk,
    input  wire        rst_n,
    psp_in_if.sink     text,
    psp_out_if.source  spec
);

    localparam int AccW = (NUMBER_BITS < 16) ? NUMBER_BITS : 16;
    localparam logic [AccW-1:0] NumMax = {AccW{1'b1}};

    phase_t          phase_reg,      phase_next;
    logic [4:0]      flags_reg,      flags_next;
    logic [AccW-1:0] width_reg,      width_next;
    logic            width_seen_reg, width_seen_next;
    logic [AccW-1:0] prec_reg,       prec_next;
    logic            prec_seen_reg,  prec_seen_next;
    logic [1:0]      len_reg,        len_next;
    logic [7:0]      count_reg,      count_next;
    logic            sat_reg,        sat_next;

    logic            out_valid_reg;
    psp_out_t        out_data_reg;
    logic            skid_valid_reg;
    psp_out_t        skid_data_reg;

    logic            accept;
    logic            out_fire;
    logic            emit;
    psp_out_t        result;

    logic [7:0]      c;
    logic            is_digit;
    logic [3:0]      digit;
    logic [AccW:0]   width_acc;
    logic [AccW:0]   prec_acc;

    // acc*10 + d, saturating; top bit flags saturation
    function automatic logic [AccW:0] accumulate(input logic [AccW-1:0] acc,
                                                 input logic [3:0] d);
        logic [AccW+3:0] v;
        v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{AccW{1'b0}}, d};
        if (v > {4'd0, NumMax})
            return {1'b1, NumMax};
        return {1'b0, v[AccW-1:0]};
    endfunction

    function automatic logic [7:0] bump(input logic [7:0] cnt, input logic [1:0] n);
        logic [8:0] s;
        s = {1'b0, cnt} + {7'd0, n};
        return s[8] ? 8'hFF : s[7:0];
    endfunction

    assign c        = text.payload.char_in;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign digit    = 4'(c - CH_ZERO);

    assign accept   = text.valid && text.ready;
    assign out_fire = out_valid_reg && spec.ready;
    assign text.ready = !skid_valid_reg;

    always_comb
    begin
        phase_t     cur_phase;
        logic [4:0] cur_flags;
        logic       cur_wseen;
        logic       cur_pseen;
        logic [1:0] cur_len;
        logic [7:0] cur_count;
        logic       cur_sat;
        logic [AccW-1:0] cur_width;
        logic [AccW-1:0] cur_prec;
        logic       do_len;
        logic       do_emit;
        logic       ended;
        logic       in_set;
        logic       unsigned_conv;
        logic [2:0] arg;

        if (text.payload.start_req)
        begin
            cur_phase = PH_FLAGS;
            cur_flags = '0;
            cur_wseen = 1'b0;
            cur_pseen = 1'b0;
            cur_len   = LEN_NONE;
            cur_count = '0;
            cur_sat   = 1'b0;
            cur_width = '0;
            cur_prec  = '0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_flags = flags_reg;
            cur_wseen = width_seen_reg;
            cur_pseen = prec_seen_reg;
            cur_len   = len_reg;
            cur_count = count_reg;
            cur_sat   = sat_reg;
            cur_width = width_reg;
            cur_prec  = prec_reg;
        end

        width_acc = accumulate(cur_width, digit);
        prec_acc  = accumulate(cur_prec, digit);

        phase_next      = cur_phase;
        flags_next      = cur_flags;
        width_next      = cur_width;
        width_seen_next = cur_wseen;
        prec_next       = cur_prec;
        prec_seen_next  = cur_pseen;
        len_next        = cur_len;
        count_next      = cur_count;
        sat_next        = cur_sat;
        do_len  = 1'b0;
        do_emit = 1'b0;
        ended   = 1'b0;

        unique case (cur_phase) inside
            PH_IDLE:
            begin
            end
            PH_DOT:
            begin
                if (is_digit)
                begin
                    prec_seen_next = 1'b1;
                    prec_next      = AccW'(digit);
                    phase_next     = PH_PREC;
                    count_next     = bump(cur_count, 2'd2);
                end
                else
                begin
                    do_emit  = 1'b1;
                    ended    = 1'b1;
                    len_next = LEN_NONE;
                end
            end
            PH_FLAGS, PH_WIDTH:
            begin
                if (cur_phase == PH_FLAGS && c == CH_MINUS)
                begin
                    flags_next[FLAG_MINUS] = 1'b1;
                    count_next = bump(cur_count, 2'd1);
                end
                else if (cur_phase == PH_FLAGS && c == CH_PLUS)
                begin
                    flags_next[FLAG_PLUS] = 1'b1;
                    count_next = bump(cur_count, 2'd1);
                end
                else if (cur_phase == PH_FLAGS && c == CH_SPACE)
                begin
                    flags_next[FLAG_SPACE] = 1'b1;
                    count_next = bump(cur_count, 2'd1);
                end
                else if (cur_phase == PH_FLAGS && c == CH_HASH)
                begin
                    flags_next[FLAG_HASH] = 1'b1;
                    count_next = bump(cur_count, 2'd1);
                end
                else if (cur_phase == PH_FLAGS && c == CH_ZERO)
                begin
                    flags_next[FLAG_ZERO] = 1'b1;
                    count_next = bump(cur_count, 2'd1);
                end
                else if (is_digit)
                begin
                    width_seen_next = 1'b1;
                    width_next      = width_acc[AccW-1:0];
                    sat_next        = cur_sat | width_acc[AccW];
                    phase_next      = PH_WIDTH;
                    count_next      = bump(cur_count, 2'd1);
                end
                else if (c == CH_DOT)
                    phase_next = PH_DOT;
                else
                    do_len = 1'b1;
            end
            PH_PREC:
            begin
                if (is_digit)
                begin
                    prec_next  = prec_acc[AccW-1:0];
                    sat_next   = cur_sat | prec_acc[AccW];
                    count_next = bump(cur_count, 2'd1);
                end
                else
                    do_len = 1'b1;
            end
            PH_LEN_H:
            begin
                if (c == CH_H)
                begin
                    phase_next = PH_SPEC;
                    count_next = bump(cur_count, 2'd1);
                end
                else
                    do_emit = 1'b1;
            end
            PH_LEN_L:
            begin
                if (c == CH_L)
                begin
                    len_next   = LEN_LL;
                    phase_next = PH_SPEC;
                    count_next = bump(cur_count, 2'd1);
                end
                else
                    do_emit = 1'b1;
            end
            PH_SPEC:
                do_emit = 1'b1;
            default:
            begin
            end
        endcase

        if (do_len)
        begin
            if (c == CH_H)
            begin
                len_next   = LEN_INT;
                phase_next = PH_LEN_H;
                count_next = bump(cur_count, 2'd1);
            end
            else if (c == CH_L)
            begin
                len_next   = LEN_LONG;
                phase_next = PH_LEN_L;
                count_next = bump(cur_count, 2'd1);
            end
            else if (c == CH_Z)
            begin
                len_next   = LEN_LL;
                phase_next = PH_SPEC;
                count_next = bump(cur_count, 2'd1);
            end
            else
                do_emit = 1'b1;
        end

        if (do_emit)
            phase_next = PH_IDLE;
        emit = do_emit;

        case (c) inside
            CH_D, CH_I, CH_U, CH_O, CH_X, CH_UX, CH_C, CH_S, CH_US, CH_P, CH_B, CH_PCT:
                in_set = !ended;
            default:
                in_set = 1'b0;
        endcase
        unsigned_conv = in_set && (c == CH_U || c == CH_O || c == CH_X || c == CH_UX);

        // unsigned conversions map the long types to their unsigned arg codes
        arg = {1'b0, len_next};
        if (unsigned_conv && len_next == LEN_LONG)
            arg = ARG_ULONG;
        else if (unsigned_conv && len_next == LEN_LL)
            arg = ARG_ULL;

        result.flags_mask           = cur_flags;
        result.has_width            = cur_wseen;
        result.width_value          = cur_wseen ? 16'(cur_width) : 16'd0;
        result.has_precision        = cur_pseen;
        result.precision_value      = cur_pseen ? 16'(cur_prec) : 16'd0;
        result.arg_type             = arg;
        result.spec_char            = in_set ? c : 8'd0;
        result.span_length          = cur_count;
        result.ended_before_current = ended;
        result.number_saturated     = cur_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            flags_reg      <= '0;
            width_reg      <= '0;
            width_seen_reg <= 1'b0;
            prec_reg       <= '0;
            prec_seen_reg  <= 1'b0;
            len_reg        <= LEN_NONE;
            count_reg      <= '0;
            sat_reg        <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            flags_reg      <= flags_next;
            width_reg      <= width_next;
            width_seen_reg <= width_seen_next;
            prec_reg       <= prec_next;
            prec_seen_reg  <= prec_seen_next;
            len_reg        <= len_next;
            count_reg      <= count_next;
            sat_reg        <= sat_next;
        end
    end

    // result register with one-entry skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
            out_valid_reg <= accept && emit;
        else if (accept && emit)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_data_reg <= skid_data_reg;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (accept && emit)
                out_data_reg <= result;
        end
        else if (accept && emit)
            skid_data_reg <= result;
    end

    assign spec.valid   = out_valid_reg;
    assign spec.payload = out_data_reg;

endmodule

`default_nettype wire
